>>> design/cht_pkg.sv
// Shared constants, codes and controller/datapath interface types for the hash table core.
package cht_pkg;

	// table geometry
	localparam int NUM_BUCKETS = 16;
	localparam int WAYS        = 4;
	localparam int KEY_BITS    = 32;

	// derived widths
	localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MOD_W = $clog2(NUM_BUCKETS + 1);
	localparam int ROW_W = WAYS * KEY_BITS;

	// remainder unit: one 4-bit digit of the key per cycle
	localparam int DIGIT_W   = 4;
	localparam int DIV_STEPS = (KEY_BITS + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD_W     = DIV_STEPS * DIGIT_W;
	localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	// stream field widths
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int BUCKET_W  = 4;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_W     = 5;

	// bucket_count value after reset
	localparam logic [CFG_W-1:0] BC_RESET = CFG_W'(16);

	// operation codes
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

	// result codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;      // take the input transfer, start the remainder
		logic div_step;  // one digit of the remainder
		logic rd;        // read the bucket row
		logic commit;    // update the row and load the result
	} cht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;  // current digit is the final one
		logic out_free;  // result register can take a new result
	} cht_sts_t;

endpackage

>>> design/cht_ctrl.sv
// Sequencing state machine for the hash table core.
module cht_ctrl
	import cht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  cht_sts_t sts,
	output cht_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		s_tready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				// hold the row until the result register has room
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/cht_dp.sv
// Datapath: remainder unit, bucket row memory, valid bits, result register, bucket_count.
module cht_dp
	import cht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cht_cmd_t              cmd,
	output cht_sts_t              sts,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [KIND_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [STATUS_W-1:0]   m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic [CFG_W-1:0]    bc_q;
	logic [MOD_W-1:0]    mod_d;
	logic [MOD_W-1:0]    mod_q;
	logic [KIND_W-1:0]   kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [PAD_W-1:0]    digits_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MOD_W-1:0]    rem_q;
	logic [MOD_W-1:0]    rem_d;
	logic [BKT_W-1:0]    bkt;

	logic [ROW_W-1:0]    slot_keys_q [NUM_BUCKETS];
	logic [ROW_W-1:0]    rdata_q;
	logic [WAYS-1:0]     valid_q [NUM_BUCKETS];
	logic [WAYS-1:0]     vrow;

	logic [WAYS-1:0]     hit;
	logic                any_hit;
	logic                any_free;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    free_way;
	logic [ROW_W-1:0]    wrow;
	logic [STATUS_W-1:0] status_d;

	logic                m_tvalid_q;
	logic [STATUS_W-1:0] status_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic                out_free;

	// configuration register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= BC_RESET;
		end else if (cfg_valid) begin
			bc_q <= cfg_data;
		end
	end

	// clamp bucket_count into 1..NUM_BUCKETS
	always_comb begin
		if (bc_q == '0) begin
			mod_d = MOD_W'(1);
		end else if (int'(bc_q) > NUM_BUCKETS) begin
			mod_d = MOD_W'(NUM_BUCKETS);
		end else begin
			mod_d = MOD_W'(bc_q);
		end
	end

	// four restoring steps per cycle, most significant digit first
	always_comb begin
		logic [MOD_W:0]        t;
		logic [MOD_W-1:0]      r;
		logic [DIGIT_W-1:0]    dig;
		r   = rem_q;
		dig = digits_q[PAD_W-1 -: DIGIT_W];
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			t = {r, dig[i]};
			if (t >= {1'b0, mod_q}) begin
				t = t - {1'b0, mod_q};
			end
			r = t[MOD_W-1:0];
		end
		rem_d = r;
	end

	assign sts.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	// item capture and remainder iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			mod_q <= MOD_W'(1);
			cnt_q <= '0;
		end else if (cmd.load) begin
			rem_q <= '0;
			mod_q <= mod_d;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_d;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= s_tuser;
			key_q    <= s_tdata[KEY_BITS-1:0];
			digits_q <= PAD_W'(s_tdata[KEY_BITS-1:0]);
		end else if (cmd.div_step) begin
			digits_q <= digits_q << DIGIT_W;
		end
	end

	assign bkt = rem_q[BKT_W-1:0];

	// bucket row memory: registered read, row write on an insert commit with a free way
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= slot_keys_q[bkt];
		end
		if (cmd.commit && kind_q == KIND_INSERT && any_free) begin
			slot_keys_q[bkt] <= wrow;
		end
	end

	// valid bits per bucket, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUCKETS; b++) begin
				valid_q[b] <= '0;
			end
		end else if (cmd.commit) begin
			if (kind_q == KIND_INSERT && any_free) begin
				valid_q[bkt][free_way] <= 1'b1;
			end else if (kind_q == KIND_DELETE && any_hit) begin
				valid_q[bkt][hit_way] <= 1'b0;
			end
		end
	end

	assign vrow = valid_q[bkt];

	// compare the row, pick lowest matching and lowest free ways
	always_comb begin
		hit_way  = '0;
		free_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit[w] = vrow[w] && (rdata_q[w*KEY_BITS +: KEY_BITS] == key_q);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit[w]) begin
				hit_way = WAY_W'(w);
			end
			if (!vrow[w]) begin
				free_way = WAY_W'(w);
			end
		end
		wrow = rdata_q;
		wrow[free_way*KEY_BITS +: KEY_BITS] = key_q;
	end

	assign any_hit  = |hit;
	assign any_free = ~&vrow;

	// result code
	always_comb begin
		case (kind_q)
			KIND_INSERT: status_d = any_free ? ST_OK : ST_FULL;
			KIND_DELETE: status_d = any_hit ? ST_OK : ST_MISS;
			default:     status_d = any_hit ? ST_OK : ST_MISS;
		endcase
	end

	// result register
	assign out_free     = !m_tvalid_q || m_tready;
	assign sts.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= status_d;
			bucket_q <= BUCKET_W'(rem_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = OUT_DATA_W'(bucket_q);

	// the remainder never reaches the modulus
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < mod_q)
		else $error("remainder not below modulus");

	// latched modulus stays within 1..NUM_BUCKETS
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mod_q != '0) && (int'(mod_q) <= NUM_BUCKETS))
		else $error("modulus out of range");

	// a commit never overwrites a result still waiting
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid_q || m_tready))
		else $error("result overwritten");

	// a commit always presents a result on the next cycle
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid_q)
		else $error("result not presented after commit");

	// at most one datapath command is active in any cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.div_step, cmd.rd, cmd.commit}))
		else $error("overlapping datapath commands");

endmodule

>>> design/chained_hash_table_core.sv
// Top level of the chained hash table core: controller and datapath.
//
// Hash set of 32-bit keys, 16 buckets of 4 slots each, bucket = key mod
// bucket_count (0 is used as 1, values above 16 as 16). Each input transfer
// (tuser = operation: 0 insert, 1 delete, 2 or 3 find; tdata = key) gives one
// result transfer (tuser = status: 0 done or hit, 1 not found, 2 bucket full;
// tdata[3:0] = bucket). From acceptance to the next acceptance, an item
// passes these steps: the remainder unit works through the key one 4-bit
// digit per cycle, then the bucket row is read from the key memory, then
// it is compared and written back; the result appears the cycle after
// that write. A waiting result does not block acceptance of the next
// item, only its final write-back. All slots are empty after reset, with no
// clearing pass. Write bucket_count only while the core is idle.
module chained_hash_table_core
	import cht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] key
	input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] bucket, [7:4] zero
	output logic [STATUS_W-1:0]   m_tuser,   // [1:0] status
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data   // bucket_count
);

	cht_cmd_t cmd;
	cht_sts_t sts;

	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

endmodule

>>> verif/tb_chained_hash_table_core.sv
// Self-checking stream testbench for the chained hash table core.
module tb_chained_hash_table_core
	import cht_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// kind 3 is not a named operation, the core treats it as a find
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int SLOTS        = NUM_BUCKETS * WAYS;
	localparam int SETTLE_CYC   = 16;   // a little over one item time
	localparam int HOLDOFF_CYC  = 400;  // long receiver hold-off
	localparam int PHASE_ITEMS  = 160;

	typedef struct {
		logic [KIND_W-1:0]   kind;
		logic [KEY_BITS-1:0] key;
		bit                  drain_first;  // sender waits for all results first
	} op_item_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [BUCKET_W-1:0] bucket;
	} result_t;

	typedef enum logic [1:0] {RCV_OPEN, RCV_HALF, RCV_SPARSE, RCV_MOSTLY} rcv_mode_t;

	// DUT signals, known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [31:0] key
	logic [KIND_W-1:0]     s_tuser   = '0;   // [1:0] kind
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // [3:0] bucket, [7:4] zero
	logic [STATUS_W-1:0]   m_tuser;          // [1:0] status
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data  = '0;   // bucket_count

	// shadow of the table and its modulus register
	logic [KEY_BITS-1:0] tbl_key [SLOTS];
	bit                  tbl_used [SLOTS];
	logic [CFG_W-1:0]    bc_shadow = BC_RESET;

	op_item_t            pend_q[$];
	result_t             result_q[$];
	logic [KEY_BITS-1:0] key_pool[$];

	int        errors     = 0;
	bit        rst_done   = 1'b0;
	bit        in_taken   = 1'b0;
	int        burst_left = 0;
	int        gap_left   = 0;
	int        hold_ask   = 0;
	int        hold_seen  = 0;
	int        hold_left  = 0;
	int        mode_left  = 0;
	rcv_mode_t rcv_mode   = RCV_OPEN;

	chained_hash_table_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("FAIL chained_hash_table_core");
		$finish;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// apply one operation to the shadow table and return its result
	function automatic result_t apply_op(logic [KIND_W-1:0] op, logic [KEY_BITS-1:0] key);
		result_t     r;
		logic [31:0] m;
		int          b;
		int          base;
		int          hit;
		int          free;
		m = (bc_shadow == 0) ? 32'd1 :
		    (bc_shadow > NUM_BUCKETS) ? 32'(NUM_BUCKETS) : 32'(bc_shadow);
		b = int'(key % m);
		base = b * WAYS;
		hit = -1;
		free = -1;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!tbl_used[base + w])
				free = w;
			else if (tbl_key[base + w] == key)
				hit = w;
		end
		r.bucket = BUCKET_W'(b);
		r.status = ST_MISS;
		if (op == KIND_INSERT) begin
			r.status = ST_FULL;
			if (free >= 0) begin
				tbl_used[base + free] = 1'b1;
				tbl_key[base + free] = key;
				r.status = ST_OK;
			end
		end else if (hit >= 0) begin
			r.status = ST_OK;
			if (op == KIND_DELETE)
				tbl_used[base + hit] = 1'b0;
		end
		return r;
	endfunction

	// monitor: results first, since they belong to earlier transfers
	always @(posedge clk) begin : mon_proc
		result_t want;
		in_taken = arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				report_mismatch("result with nothing pending", 32'({m_tuser, m_tdata}),
				                32'(0));
			end else begin
				want = result_q.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", 32'(m_tuser), 32'(want.status));
				if (m_tdata[BUCKET_W-1:0] !== want.bucket)
					report_mismatch("bucket", 32'(m_tdata[BUCKET_W-1:0]),
					                32'(want.bucket));
				if (m_tdata[OUT_DATA_W-1:BUCKET_W] !== '0)
					report_mismatch("tdata pad", 32'(m_tdata[OUT_DATA_W-1:BUCKET_W]),
					                32'(0));
			end
		end
		if (in_taken)
			result_q.insert(result_q.size(), apply_op(s_tuser, s_tdata));
	end

	// sender: bursts with random gaps, holds data until the transfer
	always @(negedge clk) begin : drv_proc
		op_item_t         it;
		logic             nv;
		logic [KEY_BITS-1:0] nd;
		logic [KIND_W-1:0] nu;
		nv = s_tvalid;
		nd = s_tdata;
		nu = s_tuser;
		if (rst_done && !(s_tvalid && !in_taken)) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pend_q.size() > 0 &&
			             !(pend_q[0].drain_first && result_q.size() != 0)) begin
				it = pend_q.pop_front();
				nv = 1'b1;
				nd = it.key;
				nu = it.kind;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		s_tvalid <= nv;
		s_tdata <= nd;
		s_tuser <= nu;
	end

	// receiver: stall pattern in modes, plus a long hold-off on request
	always @(negedge clk) begin : rcv_proc
		logic nr;
		if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			hold_left = HOLDOFF_CYC;
		end
		if (hold_left > 0) begin
			hold_left--;
			nr = 1'b0;
		end else begin
			if (mode_left == 0) begin
				rcv_mode = rcv_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(8, 80);
			end else begin
				mode_left--;
			end
			case (rcv_mode)
				RCV_OPEN:   nr = 1'b1;
				RCV_HALF:   nr = 1'($urandom_range(0, 1));
				RCV_SPARSE: nr = ($urandom_range(0, 3) == 0);
				default:    nr = ($urandom_range(0, 7) != 0);
			endcase
		end
		m_tready <= nr;
	end

	task automatic push_op(logic [KIND_W-1:0] kind, logic [KEY_BITS-1:0] key,
	                       bit drain_first = 1'b0);
		op_item_t it;
		it.kind = kind;
		it.key = key;
		it.drain_first = drain_first;
		pend_q.insert(pend_q.size(), it);
	endtask

	// mostly reuse recent keys so that hits, duplicates and full buckets occur
	task automatic gen_random(int n);
		logic [KIND_W-1:0]   kind;
		logic [KEY_BITS-1:0] key;
		int                  r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40)      kind = KIND_INSERT;
			else if (r < 70) kind = KIND_DELETE;
			else if (r < 95) kind = KIND_FIND;
			else             kind = KIND_SPARE;
			r = $urandom_range(0, 99);
			if (r < 60 && key_pool.size() > 0)
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else if (r < 80)
				key = $urandom_range(0, 63);
			else
				key = $urandom();
			if (kind == KIND_INSERT) begin
				key_pool.insert(key_pool.size(), key);
				if (key_pool.size() > 32)
					void'(key_pool.pop_front());
			end
			push_op(kind, key, i == n / 2);
		end
	endtask

	task automatic wait_idle();
		while (!(pend_q.size() == 0 && result_q.size() == 0 && !s_tvalid))
			@(posedge clk);
	endtask

	// register write only with the core idle
	task automatic write_bucket_count(logic [CFG_W-1:0] value);
		wait_idle();
		repeat (SETTLE_CYC) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		bc_shadow = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stim_proc
		logic [CFG_W-1:0] cfg_plan [9];
		cfg_plan = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd7, 5'd17, 5'd3, 5'd12, 5'd2};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		rst_done = 1'b1;

		// directed: fill bucket 0, duplicates, full insert, delete order, kind 3
		push_op(KIND_INSERT, 32'd0);
		push_op(KIND_INSERT, 32'd0);
		push_op(KIND_INSERT, 32'd16);
		push_op(KIND_INSERT, 32'd32);
		push_op(KIND_INSERT, 32'd48);
		push_op(KIND_FIND,   32'd0);
		push_op(KIND_DELETE, 32'd0);
		push_op(KIND_FIND,   32'd0);
		push_op(KIND_DELETE, 32'd0);
		push_op(KIND_FIND,   32'd0);
		push_op(KIND_DELETE, 32'd0);
		push_op(KIND_INSERT, 32'd48);
		push_op(KIND_SPARE,  32'd48);
		push_op(KIND_SPARE,  32'd7);
		push_op(KIND_INSERT, 32'hFFFF_FFFF);
		push_op(KIND_FIND,   32'hFFFF_FFFF);
		push_op(KIND_DELETE, 32'hFFFF_FFFF);
		push_op(KIND_FIND,   32'hFFFF_FFFF);
		push_op(KIND_INSERT, 32'h8000_0000);
		push_op(KIND_INSERT, 32'h7FFF_FFFF);
		push_op(KIND_FIND,   32'h5555_5555);
		push_op(KIND_FIND,   32'hAAAA_AAAA);

		// random phases across modulus settings
		for (int p = 0; p < 9; p++) begin
			write_bucket_count(cfg_plan[p]);
			if (p == 2 || p == 6)
				hold_ask++;
			gen_random(PHASE_ITEMS);
		end

		wait_idle();
		repeat (SETTLE_CYC * 2) @(posedge clk);
		if (errors == 0)
			$display("PASS chained_hash_table_core");
		else
			$display("FAIL chained_hash_table_core");
		$finish;
	end

endmodule
